@@ rtl/core/chte_pkg.sv @@
package chte_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 31;

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_SEARCH = 3'd1;
    localparam logic [2:0] REQ_UPDATE = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] CFG_KEY_LENGTH = 2'd0;
    localparam logic [1:0] CFG_TABLE_SIZE = 2'd1;
    localparam logic [1:0] CFG_HASH_MODE  = 2'd2;

    localparam int CFG_W = 9;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] value_out;
    } rsp_t;

    // weights of the first six key bytes
    function automatic logic [8:0] hash_weight(input logic [2:0] idx);
        logic [8:0] w;
        case (idx)
            3'd0:    w = 9'd257;
            3'd1:    w = 9'd123;
            3'd2:    w = 9'd61;
            3'd3:    w = 9'd31;
            3'd4:    w = 9'd17;
            3'd5:    w = 9'd11;
            default: w = 9'd0;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/chained_hash_table_engine.sv @@
// Chained hash table engine: keyed table of byte keys mapped to 31-bit values.
// Command channel: drive req and raise start; the beat is taken at a rising
// edge with start high and busy low; a hashed request holds busy high until done.
// Result channel: done is high for exactly one cycle with rsp valid; the
// receiver cannot stall, so the beat must be taken in that cycle.
// Configuration: cfg_we with cfg_index (0 key_length, 1 table_size,
// 2 hash_mode) and cfg_data; write only while busy is low.
// Sequence: clear and unknown requests complete straight from idle, busy
// staying low. Other requests run the hash (in the weighted mode one key
// byte per cycle through one shared multiply-accumulate; the integer mode
// skips it), an absolute-value step, restoring division by table_size (one
// quotient bit per cycle), the bucket read and, per chain node visited
// through the pool RAM, a read and a check; one request at a time.
// Reset: all buckets empty (flip-flop valid bits), free list full; the free
// stack needs no clearing pass, a low-water mark marks untouched entries.
// Clear request resets the same state straight from idle.
module chained_hash_table_engine #(
    parameter int BUCKETS    = 256,
    parameter int POOL_NODES = 256,
    parameter int KEY_BYTES  = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  chte_pkg::req_t                  req,
    output logic                            done,
    output chte_pkg::rsp_t                  rsp,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [chte_pkg::CFG_W-1:0]      cfg_data
);
    import chte_pkg::*;

    localparam int BW     = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
    localparam int NW     = POOL_NODES > 1 ? $clog2(POOL_NODES) : 1;
    localparam int LW     = $clog2(POOL_NODES + 1);
    localparam int EW     = KEY_W + VAL_W + LW;
    localparam int TS_CAP = BUCKETS > 511 ? 511 : BUCKETS;
    localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HASH = 4'd1;
    localparam logic [3:0] S_ABS  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_BRD  = 4'd4;
    localparam logic [3:0] S_BCHK = 4'd5;
    localparam logic [3:0] S_PRD  = 4'd6;
    localparam logic [3:0] S_PCHK = 4'd7;
    localparam logic [3:0] S_HRD  = 4'd8;
    localparam logic [3:0] S_HMV  = 4'd9;

    // configuration
    logic [3:0] key_length_reg;
    logic [8:0] table_size_reg;
    logic       hash_mode_reg;

    // sequencer and datapath
    logic [3:0]            state_reg, state_next;
    logic [2:0]            op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [VAL_W-1:0]      val_reg, val_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic                  stop_reg, stop_next;
    logic signed [31:0]    sum_reg, sum_next;
    logic [31:0]           h_reg, h_next;
    logic [9:0]            rem_reg, rem_next;
    logic [BW-1:0]         b_reg, b_next;
    logic [LW-1:0]         node_reg, node_next;
    logic [LW-1:0]         prev_reg, prev_next;
    logic [KEY_W-1:0]      pkey_reg, pkey_next;
    logic [VAL_W-1:0]      pval_reg, pval_next;
    logic [KEY_W-1:0]      bkey_reg, bkey_next;
    logic [VAL_W-1:0]      bval_reg, bval_next;
    logic [BUCKETS-1:0]    used_reg, used_next;
    logic [LW-1:0]         count_reg, count_next;
    logic [LW-1:0]         lw_reg, lw_next;
    logic                  done_reg, done_next;
    rsp_t                  rsp_reg, rsp_next;

    // memory ports
    logic          bk_we, pl_we, fs_we;
    logic [BW-1:0] bk_waddr;
    logic [NW-1:0] pl_waddr, pl_raddr, fs_waddr, fs_raddr;
    logic [EW-1:0] bk_wdata, bk_rdata, pl_wdata, pl_rdata;
    logic [NW-1:0] fs_wdata, fs_rdata;

    // combinational helpers
    logic [3:0]         len_eff;
    logic [KEY_W-1:0]   mask;
    logic [KEY_W-1:0]   req_key_m;
    logic [8:0]         ts_eff;
    logic [7:0]         cur_byte;
    logic signed [9:0]  prod_b;
    logic signed [31:0] prod;
    logic [9:0]         rem_sh;
    logic [9:0]         rem_new;
    logic [KEY_W-1:0]   bd_key, pd_key;
    logic [VAL_W-1:0]   bd_val, pd_val;
    logic [LW-1:0]      bd_link, pd_link;
    logic [LW-1:0]      top;
    logic [LW-1:0]      pop_node;

    always_comb
    begin
        len_eff = key_length_reg;
        if (key_length_reg == 4'd0)
        begin
            len_eff = 4'd1;
        end
        else if (32'(key_length_reg) > KEY_BYTES)
        begin
            len_eff = 4'(KEY_BYTES);
        end
        for (int i = 0; i < 8; i++)
        begin
            mask[8*i +: 8] = (4'(i) < len_eff) ? 8'hFF : 8'h00;
        end
        ts_eff = table_size_reg;
        if (table_size_reg == 9'd0)
        begin
            ts_eff = 9'd1;
        end
        else if (32'(table_size_reg) > BUCKETS)
        begin
            ts_eff = 9'(TS_CAP);
        end
    end

    assign req_key_m = req.key & mask;

    // shared multiply-accumulate operand: one key byte per hash cycle
    assign cur_byte = key_reg[8*cnt_reg[2:0] +: 8];
    assign prod_b   = 10'(signed'(cur_byte)) - 10'sd64;
    assign prod     = 32'(signed'({1'b0, hash_weight(cnt_reg[2:0])})) * 32'(prod_b);

    // one restoring division step
    assign rem_sh  = {rem_reg[8:0], h_reg[31]};
    assign rem_new = (rem_sh >= {1'b0, ts_eff}) ? rem_sh - {1'b0, ts_eff} : rem_sh;

    assign {bd_key, bd_val, bd_link} = bk_rdata;
    assign {pd_key, pd_val, pd_link} = pl_rdata;

    // stack entries below the low-water mark were never written since clear
    assign top      = count_reg - 1'b1;
    assign pop_node = (top < lw_reg) ? top : LW'(fs_rdata);

    assign pl_raddr = NW'(node_reg);
    assign fs_raddr = NW'(top);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        stop_next  = stop_reg;
        sum_next   = sum_reg;
        h_next     = h_reg;
        rem_next   = rem_reg;
        b_next     = b_reg;
        node_next  = node_reg;
        prev_next  = prev_reg;
        pkey_next  = pkey_reg;
        pval_next  = pval_reg;
        bkey_next  = bkey_reg;
        bval_next  = bval_reg;
        used_next  = used_reg;
        count_next = count_reg;
        lw_next    = lw_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;

        bk_we    = 1'b0;
        bk_waddr = b_reg;
        bk_wdata = {bkey_reg, bval_reg, bd_link};
        pl_we    = 1'b0;
        pl_waddr = NW'(node_reg);
        pl_wdata = pl_rdata;
        fs_we    = 1'b0;
        fs_waddr = NW'(count_reg);
        fs_wdata = NW'(node_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = req.req_type;
                    key_next  = req_key_m;
                    val_next  = req.value_in;
                    cnt_next  = 5'd0;
                    stop_next = 1'b0;
                    sum_next  = 32'sd0;
                    rem_next  = 10'd0;
                    if (req.req_type == REQ_CLEAR)
                    begin
                        // drop all entries and refill the free list at once
                        used_next  = '0;
                        count_next = NIL;
                        lw_next    = NIL;
                        done_next  = 1'b1;
                        rsp_next   = '{status: ST_DONE, value_out: '0};
                    end
                    else if (req.req_type > REQ_CLEAR)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{status: ST_MISS, value_out: '0};
                    end
                    else if (hash_mode_reg)
                    begin
                        state_next = S_ABS;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end

            S_HASH:
            begin
                if (stop_reg || cur_byte == 8'd0)
                begin
                    stop_next = 1'b1;
                end
                else if (cnt_reg < 5'd6)
                begin
                    sum_next = sum_reg + prod;
                end
                else
                begin
                    sum_next = sum_reg + 32'(signed'(cur_byte));
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd7)
                begin
                    state_next = S_ABS;
                end
            end

            S_ABS:
            begin
                if (hash_mode_reg)
                begin
                    h_next = key_reg[31] ? 32'd0 - key_reg[31:0] : key_reg[31:0];
                end
                else
                begin
                    h_next = sum_reg[31] ? 32'd0 - 32'(sum_reg) : 32'(sum_reg);
                end
                cnt_next   = 5'd0;
                rem_next   = 10'd0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                rem_next = rem_new;
                h_next   = {h_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    b_next     = BW'(rem_new);
                    state_next = S_BRD;
                end
            end

            S_BRD:
            begin
                state_next = S_BCHK;
            end

            S_BCHK:
            begin
                bkey_next  = bd_key;
                bval_next  = bd_val;
                state_next = S_IDLE;
                done_next  = 1'b1;
                rsp_next   = '{status: ST_DONE, value_out: '0};
                if (op_reg == REQ_ADD)
                begin
                    if (!used_reg[b_reg])
                    begin
                        used_next[b_reg] = 1'b1;
                        bk_we    = 1'b1;
                        bk_wdata = {key_reg, val_reg, NIL};
                    end
                    else if (count_reg == '0)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        // pop a node and link it right after the head
                        count_next = top;
                        if (top < lw_reg)
                        begin
                            lw_next = top;
                        end
                        pl_we    = 1'b1;
                        pl_waddr = NW'(pop_node);
                        pl_wdata = {key_reg, val_reg, bd_link};
                        bk_we    = 1'b1;
                        bk_wdata = {bd_key, bd_val, pop_node};
                    end
                end
                else if (!used_reg[b_reg])
                begin
                    rsp_next.status = ST_MISS;
                end
                else if ((bd_key & mask) == key_reg)
                begin
                    if (op_reg == REQ_SEARCH)
                    begin
                        rsp_next.value_out = bd_val;
                    end
                    else if (op_reg == REQ_UPDATE)
                    begin
                        bk_we    = 1'b1;
                        bk_wdata = {bd_key, val_reg, bd_link};
                    end
                    else if (bd_link != NIL)
                    begin
                        // pull the next node into the head
                        node_next  = bd_link;
                        state_next = S_HRD;
                        done_next  = 1'b0;
                    end
                    else
                    begin
                        used_next[b_reg] = 1'b0;
                    end
                end
                else if (bd_link == NIL)
                begin
                    rsp_next.status = ST_MISS;
                end
                else
                begin
                    prev_next  = NIL;
                    node_next  = bd_link;
                    state_next = S_PRD;
                    done_next  = 1'b0;
                end
            end

            S_PRD:
            begin
                state_next = S_PCHK;
            end

            S_PCHK:
            begin
                if ((pd_key & mask) == key_reg)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    rsp_next   = '{status: ST_DONE, value_out: '0};
                    if (op_reg == REQ_SEARCH)
                    begin
                        rsp_next.value_out = pd_val;
                    end
                    else if (op_reg == REQ_UPDATE)
                    begin
                        pl_we    = 1'b1;
                        pl_wdata = {pd_key, val_reg, pd_link};
                    end
                    else
                    begin
                        // unlink the node and return it to the free list
                        if (prev_reg != NIL)
                        begin
                            pl_we    = 1'b1;
                            pl_waddr = NW'(prev_reg);
                            pl_wdata = {pkey_reg, pval_reg, pd_link};
                        end
                        else
                        begin
                            bk_we    = 1'b1;
                            bk_wdata = {bkey_reg, bval_reg, pd_link};
                        end
                        if (count_reg < NIL)
                        begin
                            fs_we      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    prev_next = node_reg;
                    pkey_next = pd_key;
                    pval_next = pd_val;
                    node_next = pd_link;
                    if (pd_link == NIL)
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        rsp_next   = '{status: ST_MISS, value_out: '0};
                    end
                    else
                    begin
                        state_next = S_PRD;
                    end
                end
            end

            S_HRD:
            begin
                state_next = S_HMV;
            end

            S_HMV:
            begin
                bk_we    = 1'b1;
                bk_wdata = pl_rdata;
                if (count_reg < NIL)
                begin
                    fs_we      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = S_IDLE;
                done_next  = 1'b1;
                rsp_next   = '{status: ST_DONE, value_out: '0};
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            count_reg      <= NIL;
            lw_reg         <= NIL;
            done_reg       <= 1'b0;
            key_length_reg <= 4'd8;
            table_size_reg <= 9'd256;
            hash_mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            count_reg <= count_next;
            lw_reg    <= lw_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_LENGTH: key_length_reg <= cfg_data[3:0];
                    CFG_TABLE_SIZE: table_size_reg <= cfg_data[8:0];
                    CFG_HASH_MODE:  hash_mode_reg  <= cfg_data[0];
                    default:        ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        cnt_reg  <= cnt_next;
        stop_reg <= stop_next;
        sum_reg  <= sum_next;
        h_reg    <= h_next;
        rem_reg  <= rem_next;
        b_reg    <= b_next;
        node_reg <= node_next;
        prev_reg <= prev_next;
        pkey_reg <= pkey_next;
        pval_reg <= pval_next;
        bkey_reg <= bkey_next;
        bval_reg <= bval_next;
        rsp_reg  <= rsp_next;
    end

    chte_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_bucket_ram (
        .clk   (clk),
        .we    (bk_we),
        .waddr (bk_waddr),
        .wdata (bk_wdata),
        .raddr (b_reg),
        .rdata (bk_rdata)
    );

    chte_ram #(.WIDTH(EW), .DEPTH(POOL_NODES)) u_pool_ram (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .raddr (pl_raddr),
        .rdata (pl_rdata)
    );

    chte_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_free_ram (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;
endmodule

@@ rtl/core/chte_ram.sv @@
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ dv/tb_chained_hash_table_engine.sv @@
module tb_chained_hash_table_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import chte_pkg::*;

    localparam int NUM_BUCKETS = 256;
    localparam int NUM_NODES   = 256;
    localparam int MAX_KEY_B   = 8;
    localparam int NO_NODE     = NUM_NODES;
    localparam int KEY_SET_N   = 24;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    req_t                req;
    logic                done;
    rsp_t                rsp;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    chained_hash_table_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 4 ns period.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Table mirror: a software copy of the buckets, the overflow pool and
    // the free-node stack, plus the register values as last written.
    // ------------------------------------------------------------------
    logic [3:0]  reg_key_len;
    logic [8:0]  reg_tbl_size;
    logic        reg_hash_mode;

    bit          tbl_used  [NUM_BUCKETS];
    logic [63:0] tbl_key   [NUM_BUCKETS];
    logic [30:0] tbl_val   [NUM_BUCKETS];
    int          tbl_link  [NUM_BUCKETS];
    logic [63:0] node_key  [NUM_NODES];
    logic [30:0] node_val  [NUM_NODES];
    int          node_link [NUM_NODES];
    int          free_nodes[NUM_NODES];
    int          free_top;

    const int hash_wt[6] = '{257, 123, 61, 31, 17, 11};

    req_t        pending_reqs[$];
    rsp_t        expected_rsps[$];
    int          idle_pct;
    int          mismatch_cnt;
    int          beats_in, beats_out, hits, misses, fulls;

    function automatic void wipe_table();
        for (int i = 0; i < NUM_BUCKETS; i++) tbl_used[i] = 1'b0;
        for (int i = 0; i < NUM_NODES; i++) free_nodes[i] = i;
        free_top = NUM_NODES;
    endfunction

    // Clamp key_length into 1..8.
    function automatic int live_key_len();
        int n;
        n = reg_key_len;
        if (n == 0) n = 1;
        if (n > MAX_KEY_B) n = MAX_KEY_B;
        return n;
    endfunction

    function automatic int unsigned bucket_for(logic [63:0] k, int len);
        int          sum;
        int          i;
        int unsigned h;
        int unsigned ts;
        logic [31:0] x;
        if (reg_hash_mode) begin
            x = k[31:0];
            h = x[31] ? (32'd0 - x) : x;
        end else begin
            sum = 0;
            i = 0;
            // weighted sum over the leading nonzero bytes
            while (i < 6 && k[8*i +: 8] != 8'd0) begin
                sum += hash_wt[i] * (int'($signed(k[8*i +: 8])) - 64);
                i++;
            end
            // plain tail bytes only when the first six were all nonzero
            if (i == 6) begin
                for (int j = 6; j < len; j++) begin
                    if (k[8*j +: 8] == 8'd0) break;
                    sum += int'($signed(k[8*j +: 8]));
                end
            end
            h = (sum < 0) ? -sum : sum;
        end
        ts = reg_tbl_size;
        if (ts == 0) ts = 1;
        if (ts > NUM_BUCKETS) ts = NUM_BUCKETS;
        return h % ts;
    endfunction

    function automatic void release_node(int n);
        if (free_top < NUM_NODES) begin
            free_nodes[free_top] = n;
            free_top++;
        end
    endfunction

    // Apply one request to the mirror and return the response it must give.
    function automatic rsp_t apply_request(req_t r);
        rsp_t        o;
        int          len;
        logic [63:0] mask;
        logic [63:0] k;
        int unsigned b;
        int          n, prev, steps;
        o.status    = ST_MISS;
        o.value_out = '0;
        len  = live_key_len();
        mask = (len >= 8) ? '1 : ((64'd1 << (8*len)) - 64'd1);
        k    = r.key & mask;
        if (r.req_type == REQ_CLEAR) begin
            wipe_table();
            o.status = ST_DONE;
        end else if (r.req_type == REQ_ADD) begin
            b = bucket_for(k, len);
            if (!tbl_used[b]) begin
                tbl_used[b] = 1'b1;
                tbl_key[b]  = k;
                tbl_val[b]  = r.value_in;
                tbl_link[b] = NO_NODE;
                o.status    = ST_DONE;
            end else if (free_top == 0) begin
                o.status = ST_FULL;
            end else begin
                free_top--;
                n = free_nodes[free_top];
                node_key[n]  = k;
                node_val[n]  = r.value_in;
                node_link[n] = tbl_link[b];
                tbl_link[b]  = n;
                o.status     = ST_DONE;
            end
        end else if (r.req_type inside {REQ_SEARCH, REQ_UPDATE, REQ_REMOVE}) begin
            b = bucket_for(k, len);
            if (tbl_used[b]) begin
                if ((tbl_key[b] & mask) == k) begin
                    o.status = ST_DONE;
                    if (r.req_type == REQ_SEARCH) o.value_out = tbl_val[b];
                    else if (r.req_type == REQ_UPDATE) tbl_val[b] = r.value_in;
                    else begin
                        // removing the head pulls the next node inline
                        n = tbl_link[b];
                        if (n < NUM_NODES) begin
                            tbl_key[b]  = node_key[n];
                            tbl_val[b]  = node_val[n];
                            tbl_link[b] = node_link[n];
                            release_node(n);
                        end else begin
                            tbl_used[b] = 1'b0;
                        end
                    end
                end else begin
                    prev  = NO_NODE;
                    n     = tbl_link[b];
                    steps = 0;
                    while (n < NUM_NODES && steps <= NUM_NODES) begin
                        if ((node_key[n] & mask) == k) begin
                            o.status = ST_DONE;
                            if (r.req_type == REQ_SEARCH) o.value_out = node_val[n];
                            else if (r.req_type == REQ_UPDATE) node_val[n] = r.value_in;
                            else begin
                                if (prev < NUM_NODES) node_link[prev] = node_link[n];
                                else tbl_link[b] = node_link[n];
                                release_node(n);
                            end
                            break;
                        end
                        prev = n;
                        n    = node_link[n];
                        steps++;
                    end
                end
            end
        end
        return o;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        mismatch_cnt++;
        $display("[%0t] MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Driver: hold the beat until the block takes it, then either present
    // the next pending request or drop start for an idle cycle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
            req   <= '0;
        end else if (!start || !busy) begin
            if (start) begin
                expected_rsps.push_back(apply_request(req));
                beats_in++;
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                req   <= pending_reqs.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done beat must match the oldest pending expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && done) begin
            beats_out++;
            if (expected_rsps.size() == 0) begin
                report("response with nothing outstanding", rsp, 0);
            end else begin
                rsp_t want;
                want = expected_rsps.pop_front();
                if (rsp.status !== want.status) report("status", rsp.status, want.status);
                if (rsp.value_out !== want.value_out)
                    report("value_out", rsp.value_out, want.value_out);
                if (want.status == ST_DONE && want.value_out != 0) hits++;
                if (want.status == ST_MISS) misses++;
                if (want.status == ST_FULL) fulls++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [63:0] key_set[KEY_SET_N];

    task automatic queue_req(logic [2:0] op, logic [63:0] k, logic [30:0] v);
        req_t r;
        r.req_type = op;
        r.key      = k;
        r.value_in = v;
        pending_reqs.push_back(r);
    endtask

    // Wait until every queued beat is accepted and every response is back.
    task automatic drain();
        do @(posedge clk);
        while (pending_reqs.size() != 0 || start || busy || expected_rsps.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_KEY_LENGTH) reg_key_len = data[3:0];
        else if (idx == CFG_TABLE_SIZE) reg_tbl_size = data[8:0];
        else if (idx == CFG_HASH_MODE) reg_hash_mode = data[0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random key with a fair chance of zero bytes, which cut the hash short.
    function automatic logic [63:0] fresh_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        if ($urandom_range(3) == 0) k[8*$urandom_range(7) +: 8] = 8'd0;
        if ($urandom_range(5) == 0) k = k & ((64'd1 << (8*$urandom_range(1, 7))) - 64'd1);
        return k;
    endfunction

    // Mostly a small recurring key set so adds, hits and removes collide.
    task automatic queue_random(int count);
        int          sel;
        logic [2:0]  op;
        logic [63:0] k;
        for (int i = 0; i < KEY_SET_N; i++) key_set[i] = fresh_key();
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 34) op = REQ_ADD;
            else if (sel < 60) op = REQ_SEARCH;
            else if (sel < 75) op = REQ_UPDATE;
            else if (sel < 95) op = REQ_REMOVE;
            else if (sel < 97) op = REQ_CLEAR;
            else op = 3'($urandom_range(5, 7));
            k = ($urandom_range(99) < 85) ? key_set[$urandom_range(KEY_SET_N - 1)]
                                          : fresh_key();
            queue_req(op, k, 31'($urandom));
        end
    endtask

    task automatic random_phase(int kl, int ts, int hm, int pct, int count);
        write_reg(CFG_KEY_LENGTH, CFG_W'(kl));
        write_reg(CFG_TABLE_SIZE, CFG_W'(ts));
        write_reg(CFG_HASH_MODE, CFG_W'(hm));
        idle_pct = pct;
        queue_random(count);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        reg_key_len   = 4'd8;
        reg_tbl_size  = 9'd256;
        reg_hash_mode = 1'b0;
        idle_pct      = 0;
        mismatch_cnt  = 0;
        beats_in      = 0;
        beats_out     = 0;
        hits          = 0;
        misses        = 0;
        fulls         = 0;
        wipe_table();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: extreme keys and values, every request type, unknown codes.
        queue_req(REQ_ADD,    '1, '1);
        queue_req(REQ_SEARCH, '1, '0);
        queue_req(REQ_ADD,    '0, '0);
        queue_req(REQ_SEARCH, '0, '1);
        queue_req(REQ_UPDATE, '1, 31'h2AAA_5555);
        queue_req(REQ_SEARCH, '1, '0);
        queue_req(REQ_REMOVE, '1, '0);
        queue_req(REQ_SEARCH, '1, '0);
        queue_req(REQ_REMOVE, '1, '0);
        queue_req(REQ_UPDATE, 64'h0102_0304_0506_0708, '1);
        queue_req(3'd5, 64'h55, '1);
        queue_req(3'd6, '0, '0);
        queue_req(3'd7, '1, '1);
        queue_req(REQ_CLEAR,  '0, '0);
        queue_req(REQ_SEARCH, '0, '0);
        drain();

        // Directed, integer hash: the most negative integer and minus one.
        write_reg(CFG_HASH_MODE, CFG_W'(1));
        queue_req(REQ_ADD,    64'h8000_0000, 31'd11);
        queue_req(REQ_ADD,    64'hFFFF_FFFF, 31'd22);
        queue_req(REQ_ADD,    64'h1_8000_0000, 31'd33);
        queue_req(REQ_SEARCH, 64'h8000_0000, '0);
        queue_req(REQ_SEARCH, 64'h1_8000_0000, '0);
        queue_req(REQ_SEARCH, 64'hFFFF_FFFF, '0);
        queue_req(REQ_CLEAR,  '0, '0);
        drain();

        // One bucket: fill the whole overflow pool, hit the full status,
        // then remove the head and a chain node and reuse freed nodes.
        write_reg(CFG_HASH_MODE, CFG_W'(0));
        write_reg(CFG_TABLE_SIZE, CFG_W'(1));
        idle_pct = 7;
        for (int i = 0; i < NUM_NODES + 3; i++)
            queue_req(REQ_ADD, {32'h00A5_0000, 32'(i + 1)}, 31'(i * 7 + 1));
        queue_req(REQ_SEARCH, {32'h00A5_0000, 32'd1}, '0);
        queue_req(REQ_SEARCH, {32'h00A5_0000, 32'd2}, '0);
        queue_req(REQ_REMOVE, {32'h00A5_0000, 32'd1}, '0);
        queue_req(REQ_REMOVE, {32'h00A5_0000, 32'd100}, '0);
        queue_req(REQ_SEARCH, {32'h00A5_0000, 32'd2}, '0);
        queue_req(REQ_ADD,    64'h77, 31'd5);
        queue_req(REQ_ADD,    64'h78, 31'd6);
        queue_req(REQ_ADD,    64'h79, 31'd7);
        queue_req(REQ_SEARCH, 64'h78, '0);
        queue_req(REQ_CLEAR,  '0, '0);
        drain();

        // Random phases across register settings, out-of-range ones included;
        // rotate sender idling among none, heavy and light.
        random_phase(3,  4,   0, 0,  120);
        random_phase(8,  256, 1, 77, 120);
        random_phase(1,  2,   1, 7,  120);
        random_phase(0,  0,   0, 0,  100);
        random_phase(15, 300, 0, 77, 120);
        random_phase(2,  7,   1, 7,  120);
        random_phase(8,  511, 0, 0,  120);
        random_phase(5,  3,   0, 77, 120);
        random_phase(4,  16,  1, 7,  120);
        random_phase(8,  1,   0, 0,  100);

        repeat (60) @(posedge clk);
        $display("Covered %0d requests and %0d responses over 13 register settings",
                 beats_in, beats_out);
        $display("Responses: %0d nonzero hits, %0d misses, %0d pool-full", hits, misses, fulls);
        if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("Watchdog expired with %0d responses outstanding", expected_rsps.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/chte_pkg.sv
rtl/core/chte_ram.sv
rtl/core/chained_hash_table_engine.sv
dv/tb_chained_hash_table_engine.sv
